// ----- design/lzssfb_pkg.sv -----
`default_nettype none

package lzssfb_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int RING_AW    = 12;
    localparam int DIST_W     = 13;
    localparam int LEN_W      = 9;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_start;
    } item_t;

    typedef struct packed {
        logic [63:0] out_data;
        logic [3:0]  out_count;
        logic        stream_end;
        logic        distance_error;
        logic        last_of_run;
    } result_t;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_MATCH,
        CMD_END
    } cmd_kind_t;

    // request from the token parser to the copy engine
    typedef struct packed {
        logic              valid;
        logic              hist_clr;
        cmd_kind_t         kind;
        logic [7:0]        lit;
        logic [DIST_W-1:0] match_dist;
        logic [LEN_W-1:0]  len;
    } cmd_t;

endpackage

`default_nettype wire

// ----- design/lzss_flag_bit_decompressor.sv -----
// a literal byte is registered, sent to the copy engine in the step state, written to the
// ring and shown from the emit state as a registered beat; a flag or match header byte walks
// its flag bits in the step state, no beat; each match byte passes a read then a write state
// for the registered ring read, and each beat passes the emit state; input stalls meanwhile
// reset clears parser, counters and beat valid; ring contents are not cleared
`default_nettype none

module lzss_flag_bit_decompressor #(
    parameter int BYTES_PER_RESULT = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire lzssfb_pkg::item_t   item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output lzssfb_pkg::result_t      result
);

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } state_t;

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_KIND,
        PH_LEN1,
        PH_LEN2,
        PH_SDIST,
        PH_LHI,
        PH_LLO,
        PH_LEXTRA
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  byte_reg, byte_next;
    logic [7:0]  fs_reg, fs_next;
    logic [3:0]  bl_reg, bl_next;
    logic [7:0]  mhb_reg, mhb_next;
    logic [3:0]  dln_reg, dln_next;
    logic [1:0]  slb_reg, slb_next;
    logic        fin_reg, fin_next;

    lzssfb_pkg::cmd_t cmd;
    logic             eng_ready;
    logic             flag_bit;
    logic [15:0]      word;
    logic [11:0]      dist12;

    lzssfb_copy #(
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_copy (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cmd_ready    (eng_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign item_stall = (state_reg != ST_IDLE) || !eng_ready;
    assign flag_bit   = fs_reg[0];
    assign word       = {mhb_reg, byte_reg};

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        byte_next  = byte_reg;
        fs_next    = fs_reg;
        bl_next    = bl_reg;
        mhb_next   = mhb_reg;
        dln_next   = dln_reg;
        slb_next   = slb_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        dist12     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && !item_stall)
                begin
                    byte_next  = item.in_byte;
                    state_next = ST_STEP;
                    if (item.stream_start)
                    begin
                        cmd.hist_clr = 1'b1;
                        phase_next   = PH_TOKEN;
                        fs_next      = '0;
                        bl_next      = '0;
                        mhb_next     = '0;
                        dln_next     = '0;
                        slb_next     = '0;
                        fin_next     = 1'b0;
                    end
                    else if (fin_reg)
                    begin
                        // after the end marker bytes are dropped
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_STEP:
            begin
                if ((phase_reg inside {PH_TOKEN, PH_KIND, PH_LEN1, PH_LEN2}) && bl_reg == '0)
                begin
                    fs_next    = byte_reg;
                    bl_next    = 4'd8;
                    state_next = ST_IDLE;
                end
                else
                begin
                    case (phase_reg)
                        PH_TOKEN:
                        begin
                            if (!flag_bit)
                            begin
                                cmd.valid = 1'b1;
                                cmd.kind  = lzssfb_pkg::CMD_LIT;
                                cmd.lit   = byte_reg;
                                if (eng_ready)
                                begin
                                    fs_next    = fs_reg >> 1;
                                    bl_next    = bl_reg - 1'b1;
                                    state_next = ST_IDLE;
                                end
                            end
                            else
                            begin
                                fs_next    = fs_reg >> 1;
                                bl_next    = bl_reg - 1'b1;
                                phase_next = PH_KIND;
                            end
                        end
                        PH_KIND:
                        begin
                            fs_next    = fs_reg >> 1;
                            bl_next    = bl_reg - 1'b1;
                            phase_next = flag_bit ? PH_LEN1 : PH_LHI;
                        end
                        PH_LEN1:
                        begin
                            fs_next    = fs_reg >> 1;
                            bl_next    = bl_reg - 1'b1;
                            slb_next   = {flag_bit, 1'b0};
                            phase_next = PH_LEN2;
                        end
                        PH_LEN2:
                        begin
                            fs_next    = fs_reg >> 1;
                            bl_next    = bl_reg - 1'b1;
                            slb_next   = {slb_reg[1], flag_bit};
                            phase_next = PH_SDIST;
                        end
                        PH_SDIST:
                        begin
                            // a distance byte of zero reaches back 256
                            cmd.valid      = 1'b1;
                            cmd.kind       = lzssfb_pkg::CMD_MATCH;
                            cmd.match_dist = (byte_reg == 8'd0) ? 13'd256 : {5'd0, byte_reg};
                            cmd.len        = {7'd0, slb_reg} + 9'd2;
                            if (eng_ready)
                            begin
                                phase_next = PH_TOKEN;
                                state_next = ST_IDLE;
                            end
                        end
                        PH_LHI:
                        begin
                            mhb_next   = byte_reg;
                            phase_next = PH_LLO;
                            state_next = ST_IDLE;
                        end
                        PH_LLO:
                        begin
                            dist12 = word[15:4];
                            if (word == 16'd0)
                            begin
                                cmd.valid = 1'b1;
                                cmd.kind  = lzssfb_pkg::CMD_END;
                                if (eng_ready)
                                begin
                                    fin_next   = 1'b1;
                                    phase_next = PH_TOKEN;
                                    state_next = ST_IDLE;
                                end
                            end
                            else if (word[3:0] == 4'd0)
                            begin
                                dln_next   = byte_reg[7:4];
                                phase_next = PH_LEXTRA;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                cmd.valid      = 1'b1;
                                cmd.kind       = lzssfb_pkg::CMD_MATCH;
                                cmd.match_dist = (dist12 == '0) ?
                                                 13'(lzssfb_pkg::RING_DEPTH) : {1'b0, dist12};
                                cmd.len        = {5'd0, word[3:0]} + 9'd2;
                                if (eng_ready)
                                begin
                                    phase_next = PH_TOKEN;
                                    state_next = ST_IDLE;
                                end
                            end
                        end
                        PH_LEXTRA:
                        begin
                            dist12         = {mhb_reg, dln_reg};
                            cmd.valid      = 1'b1;
                            cmd.kind       = lzssfb_pkg::CMD_MATCH;
                            cmd.match_dist = (dist12 == '0) ?
                                             13'(lzssfb_pkg::RING_DEPTH) : {1'b0, dist12};
                            cmd.len        = {1'b0, byte_reg} + 9'd1;
                            if (eng_ready)
                            begin
                                phase_next = PH_TOKEN;
                                state_next = ST_IDLE;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_TOKEN;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_TOKEN;
            fs_reg    <= '0;
            bl_reg    <= '0;
            mhb_reg   <= '0;
            dln_reg   <= '0;
            slb_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            fs_reg    <= fs_next;
            bl_reg    <= bl_next;
            mhb_reg   <= mhb_next;
            dln_reg   <= dln_next;
            slb_reg   <= slb_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

// ----- design/lzssfb_ram.sv -----
`default_nettype none

module lzssfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/lzssfb_copy.sv -----
`default_nettype none

module lzssfb_copy #(
    parameter int BYTES_PER_RESULT = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lzssfb_pkg::cmd_t    cmd,
    output logic                     cmd_ready,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output lzssfb_pkg::result_t      result
);

    localparam logic [3:0] BPR_W = 4'(BYTES_PER_RESULT);

    typedef enum logic [1:0] {
        E_IDLE,
        E_READ,
        E_WRITE,
        E_EMIT
    } eng_state_t;

    eng_state_t                          state_reg, state_next;
    logic [lzssfb_pkg::RING_AW-1:0]      wp_reg, wp_next;
    logic [lzssfb_pkg::DIST_W-1:0]       prod_reg, prod_next;
    logic [lzssfb_pkg::DIST_W-1:0]       dist_reg, dist_next;
    logic [lzssfb_pkg::LEN_W-1:0]        rem_reg, rem_next;
    logic                                bad_reg, bad_next;
    logic                                end_reg, end_next;
    logic [63:0]                         acc_reg, acc_next;
    logic [3:0]                          fill_reg, fill_next;
    logic                                res_valid_reg, res_valid_next;
    lzssfb_pkg::result_t                 res_reg, res_next;

    logic                                ram_we;
    logic [lzssfb_pkg::RING_AW-1:0]      ram_waddr;
    logic [7:0]                          ram_wdata;
    logic [lzssfb_pkg::RING_AW-1:0]      ram_raddr;
    logic [7:0]                          ram_rdata;
    logic [7:0]                          copy_byte;
    logic                                can_push;
    logic [lzssfb_pkg::DIST_W-1:0]       prod_inc;

    lzssfb_ram #(
        .WIDTH (8),
        .DEPTH (lzssfb_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_ready    = (state_reg == E_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign can_push     = !res_valid_reg || !result_stall;
    assign ram_raddr    = wp_reg - dist_reg[lzssfb_pkg::RING_AW-1:0];
    assign copy_byte    = bad_reg ? 8'd0 : ram_rdata;
    assign prod_inc     = (prod_reg == lzssfb_pkg::DIST_W'(lzssfb_pkg::RING_DEPTH)) ?
                          prod_reg : prod_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        prod_next      = prod_reg;
        dist_next      = dist_reg;
        rem_next       = rem_reg;
        bad_next       = bad_reg;
        end_next       = end_reg;
        acc_next       = acc_reg;
        fill_next      = fill_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && result_stall;
        ram_we         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = copy_byte;

        case (state_reg)
            E_IDLE:
            begin
                if (cmd.hist_clr)
                begin
                    prod_next = '0;
                end
                if (cmd.valid)
                begin
                    acc_next  = '0;
                    fill_next = '0;
                    bad_next  = 1'b0;
                    end_next  = 1'b0;
                    rem_next  = '0;
                    case (cmd.kind)
                        lzssfb_pkg::CMD_LIT:
                        begin
                            ram_we         = 1'b1;
                            ram_wdata      = cmd.lit;
                            wp_next        = wp_reg + 1'b1;
                            prod_next      = prod_inc;
                            acc_next[7:0]  = cmd.lit;
                            fill_next      = 4'd1;
                            state_next     = E_EMIT;
                        end
                        lzssfb_pkg::CMD_MATCH:
                        begin
                            dist_next  = cmd.match_dist;
                            rem_next   = cmd.len;
                            bad_next   = cmd.match_dist > prod_reg;
                            state_next = E_READ;
                        end
                        lzssfb_pkg::CMD_END:
                        begin
                            end_next   = 1'b1;
                            state_next = E_EMIT;
                        end
                        default:
                        begin
                            state_next = E_IDLE;
                        end
                    endcase
                end
            end
            E_READ:
            begin
                state_next = E_WRITE;
            end
            E_WRITE:
            begin
                // one history byte per pass, written back behind the copy
                ram_we    = 1'b1;
                wp_next   = wp_reg + 1'b1;
                prod_next = prod_inc;
                for (int l = 0; l < 8; l++)
                begin
                    if (fill_reg[2:0] == 3'(l))
                    begin
                        acc_next[8*l +: 8] = copy_byte;
                    end
                end
                fill_next = fill_reg + 1'b1;
                rem_next  = rem_reg - 1'b1;
                if ((fill_reg + 1'b1 == BPR_W) || (rem_reg == 9'd1))
                begin
                    state_next = E_EMIT;
                end
                else
                begin
                    state_next = E_READ;
                end
            end
            E_EMIT:
            begin
                if (can_push)
                begin
                    res_valid_next          = 1'b1;
                    res_next.out_data       = acc_reg;
                    res_next.out_count      = fill_reg;
                    res_next.stream_end     = end_reg;
                    res_next.distance_error = bad_reg;
                    res_next.last_of_run    = (rem_reg == '0);
                    acc_next                = '0;
                    fill_next               = '0;
                    state_next              = (rem_reg == '0) ? E_IDLE : E_READ;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            wp_reg        <= '0;
            prod_reg      <= '0;
            rem_reg       <= '0;
            fill_reg      <= '0;
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            prod_reg      <= prod_next;
            rem_reg       <= rem_next;
            fill_reg      <= fill_next;
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        bad_reg  <= bad_next;
        end_reg  <= end_next;
        res_reg  <= res_next;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= BPR_W)
        else $error("beat fill beyond result width");

    a_write_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == E_WRITE |-> rem_reg != '0)
        else $error("copy step with nothing left");

    a_prod_sat: assert property (@(posedge clk) disable iff (!rst_n)
        prod_reg <= lzssfb_pkg::DIST_W'(lzssfb_pkg::RING_DEPTH))
        else $error("history count past window");

    a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.stream_end |->
            res_reg.out_count == '0 && !res_reg.distance_error)
        else $error("end marker beat carries data");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == E_EMIT && can_push |=> res_valid_reg)
        else $error("emitted beat lost");
`endif

endmodule

`default_nettype wire
